// ----- sv/dasp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, field layout and constants of the dual-axis step pulse generator.
package dasp_pkg;

    localparam int RATE_W   = 16;
    localparam int FLEN_W   = 4;
    localparam int THRESH_W = 24;

    localparam logic [FLEN_W-1:0]   MIN_FRAME_LEN = 4'd5;
    localparam logic [THRESH_W-1:0] THRESH_RESET  = 24'd100000;

    // Input tdata layout, lowest bit first
    localparam int S_FLEN_LSB  = 0;
    localparam int S_AZR_LSB   = S_FLEN_LSB + FLEN_W;
    localparam int S_ELR_LSB   = S_AZR_LSB + RATE_W;
    localparam int S_AZD_BIT   = S_ELR_LSB + RATE_W;
    localparam int S_ELD_BIT   = S_AZD_BIT + 1;
    localparam int S_STOP_BIT  = S_ELD_BIT + 1;
    localparam int S_TDATA_W   = 40;

    // Output tdata layout, lowest bit first
    localparam int M_AZ_STEP   = 0;
    localparam int M_EL_STEP   = 1;
    localparam int M_AZ_DIR    = 2;
    localparam int M_EL_DIR    = 3;
    localparam int M_AZ_EN     = 4;
    localparam int M_EL_EN     = 5;
    localparam int M_STOPPED   = 6;
    localparam int M_TDATA_W   = 8;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_CMD  = 1'b1
    } op_t;

    // Per-axis controls for one processed item
    typedef struct packed {
        logic tick;   // advance the accumulator
        logic load;   // take a new rate
        logic clear;  // zero the rate (emergency stop)
    } axis_ctrl_t;

endpackage

// ----- sv/dasp_axis.sv -----
`timescale 1ns / 1ps
// One axis: rate register and saturating phase accumulator with threshold wrap.
module dasp_axis
    import dasp_pkg::*;
#(
    parameter int PHASE_WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  axis_ctrl_t               ctrl,
    input  logic [RATE_W-1:0]        rate,
    input  logic [THRESH_W-1:0]      threshold,
    output logic                     toggle
);

    localparam int SUM_W = PHASE_WIDTH + 1;
    localparam int CMP_W = ((PHASE_WIDTH > THRESH_W) ? PHASE_WIDTH : THRESH_W) + 1;

    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [RATE_W-1:0]      speed_reg, speed_next;
    logic [SUM_W-1:0]       sum;
    logic [PHASE_WIDTH-1:0] sat;
    logic [CMP_W-1:0]       sat_ext, thr_ext, diff;
    logic                   hit;

    always_comb begin
        sum = {phase_reg[PHASE_WIDTH-1], phase_reg}
            + {{(SUM_W-RATE_W){speed_reg[RATE_W-1]}}, speed_reg};
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            // clamp to the signed limits
            sat = sum[SUM_W-1] ? {1'b1, {(PHASE_WIDTH-1){1'b0}}}
                               : {1'b0, {(PHASE_WIDTH-1){1'b1}}};
        end else begin
            sat = sum[PHASE_WIDTH-1:0];
        end
        sat_ext = {{(CMP_W-PHASE_WIDTH){sat[PHASE_WIDTH-1]}}, sat};
        thr_ext = {{(CMP_W-THRESH_W){1'b0}}, threshold};
        hit     = $signed(sat_ext) >= $signed(thr_ext);
        diff    = sat_ext - thr_ext;
        phase_next = hit ? diff[PHASE_WIDTH-1:0] : sat;
    end

    always_comb begin
        speed_next = speed_reg;
        if (ctrl.clear) begin
            speed_next = '0;
        end else if (ctrl.load) begin
            speed_next = rate;
        end
    end

    assign toggle = ctrl.tick & hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            speed_reg <= '0;
        end else begin
            if (ctrl.tick) begin
                phase_reg <= phase_next;
            end
            speed_reg <= speed_next;
        end
    end

endmodule

// ----- sv/dual_axis_stepper_pulse_generator.sv -----
`timescale 1ns / 1ps
// Top level of the dual-axis stepper pulse generator.
//
// Usage:
//   Each item on the s_ stream is a timer tick (s_tuser = 0) or a motor
//   command (s_tuser = 1). Every item yields exactly one item on the m_
//   stream: the six pin levels and the stop flag after that item is applied.
//   A command with frame_length below 5 changes nothing; a command with
//   stop_request set zeroes both rates, drops both enables and sets stopped;
//   any other command clears stopped, raises both enables and loads the
//   directions and rates. Ticks advance the two phase accumulators unless
//   stopped; each accumulator that reaches step_threshold wraps and toggles
//   its step pin.
//   step_threshold is written through cfg_valid/cfg_data (always ready);
//   write it only while the block is idle.
// Timing:
//   An accepted item is registered in the input register; the result register
//   then loads behind the accumulator add and compare, and m_tvalid rises
//   with it. Throughput is one item per cycle while m_tready stays high.
// Reset and stalls:
//   aresetn (synchronous, active low) clears accumulators, rates, pins, stop
//   and both valid flags, and reloads step_threshold with 100000.
//   When m_tready is low the result holds, the input stage holds, and
//   s_tready drops once the input register is occupied.
module dual_axis_stepper_pulse_generator
    import dasp_pkg::*;
#(
    parameter int PHASE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [THRESH_W-1:0]   cfg_data,       // step_threshold
    // input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [3:0] frame_length, [19:4] az_rate, [35:20] el_rate, [36] az_direction,
    // [37] el_direction, [38] stop_request, [39] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]            s_tuser,        // [0] opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] az_step_level, [1] el_step_level, [2] az_dir_level, [3] el_dir_level,
    // [4] az_enable, [5] el_enable, [6] stopped, [7] zero
    output logic [M_TDATA_W-1:0]  m_tdata
);

    // threshold register
    logic [THRESH_W-1:0] thresh_reg;

    // input stage
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [FLEN_W-1:0]   in_flen_reg;
    logic [RATE_W-1:0]   in_az_rate_reg, in_el_rate_reg;
    logic                in_az_dir_reg, in_el_dir_reg, in_stop_reg;

    // block state and result register
    logic                stop_reg, stop_next;
    logic [5:0]          pins_reg, pins_next;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                advance, process, s_accept;
    logic                cmd_ok, do_tick, do_estop, do_go;
    axis_ctrl_t          az_ctrl, el_ctrl;
    logic                az_toggle, el_toggle;

    assign cfg_ready = 1'b1;

    // Advance the result register when it is empty or being taken
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign process  = in_valid_reg && advance;

    always_comb begin
        cmd_ok   = (in_op_reg == OP_CMD) && (in_flen_reg >= MIN_FRAME_LEN);
        do_tick  = process && (in_op_reg == OP_TICK) && !stop_reg;
        do_estop = process && cmd_ok && in_stop_reg;
        do_go    = process && cmd_ok && !in_stop_reg;

        az_ctrl.tick  = do_tick;
        az_ctrl.load  = do_go;
        az_ctrl.clear = do_estop;
        el_ctrl       = az_ctrl;
    end

    dasp_axis #(.PHASE_WIDTH(PHASE_WIDTH)) u_az (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (az_ctrl),
        .rate      (in_az_rate_reg),
        .threshold (thresh_reg),
        .toggle    (az_toggle)
    );

    dasp_axis #(.PHASE_WIDTH(PHASE_WIDTH)) u_el (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (el_ctrl),
        .rate      (in_el_rate_reg),
        .threshold (thresh_reg),
        .toggle    (el_toggle)
    );

    // Next pin levels and stop flag for the item in the input stage
    always_comb begin
        pins_next = pins_reg;
        stop_next = stop_reg;
        pins_next[M_AZ_STEP] = pins_reg[M_AZ_STEP] ^ az_toggle;
        pins_next[M_EL_STEP] = pins_reg[M_EL_STEP] ^ el_toggle;
        if (do_estop) begin
            stop_next          = 1'b1;
            pins_next[M_AZ_EN] = 1'b0;
            pins_next[M_EL_EN] = 1'b0;
        end else if (do_go) begin
            stop_next           = 1'b0;
            pins_next[M_AZ_EN]  = 1'b1;
            pins_next[M_EL_EN]  = 1'b1;
            pins_next[M_AZ_DIR] = in_az_dir_reg;
            pins_next[M_EL_DIR] = in_el_dir_reg;
        end
        m_tdata_next = {1'b0, stop_next, pins_next};
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg   <= THRESH_RESET;
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            stop_reg     <= 1'b0;
            pins_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (process) begin
                m_tvalid_reg <= 1'b1;
                stop_reg     <= stop_next;
                pins_reg     <= pins_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg      <= op_t'(s_tuser[0]);
            in_flen_reg    <= s_tdata[S_FLEN_LSB +: FLEN_W];
            in_az_rate_reg <= s_tdata[S_AZR_LSB +: RATE_W];
            in_el_rate_reg <= s_tdata[S_ELR_LSB +: RATE_W];
            in_az_dir_reg  <= s_tdata[S_AZD_BIT];
            in_el_dir_reg  <= s_tdata[S_ELD_BIT];
            in_stop_reg    <= s_tdata[S_STOP_BIT];
        end
        if (process) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- sv/dasp_checker.sv -----
`timescale 1ns / 1ps
// Port-level assertions for the dual-axis step pulse generator, bound to the top.
module dasp_checker
    import dasp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result right after reset
    a_rst: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // Stop always drops both enables
    a_stop_en: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[M_STOPPED] |-> !m_tdata[M_AZ_EN] && !m_tdata[M_EL_EN])
        else $error("enable high while stopped");

    // Both enables move together
    a_en_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_AZ_EN] == m_tdata[M_EL_EN])
        else $error("axis enables differ");

    // An empty result register never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind dual_axis_stepper_pulse_generator dasp_checker u_dasp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
